// ===== rtl/utpc_pkg.sv =====
// Package for the UDP/TCP port classifier: field widths, kind codes,
// well-known port tables and the service-to-dissector decode. No dependencies.
`default_nettype none
package utpc_pkg;
  localparam int TRANSIENT_DEPTH = 64;
  localparam int TIDX_W = $clog2(TRANSIENT_DEPTH);
  localparam int TCNT_W = TIDX_W + 1;

  localparam logic [1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_DELETE   = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [3:0] DIS_NONE      = 4'd0;
  localparam logic [3:0] DIS_TRANSIENT = 4'd1;
  localparam logic [3:0] DIS_DNS       = 4'd2;
  localparam logic [3:0] DIS_GENERIC   = 4'd15;

  localparam int UDP_N = 25;
  localparam int TCP_N = 51;

  localparam logic [15:0] UDP_PORTS [UDP_N] = '{
    16'd7, 16'd9, 16'd13, 16'd19, 16'd37, 16'd42, 16'd53, 16'd67, 16'd68, 16'd69,
    16'd79, 16'd123, 16'd137, 16'd138, 16'd427, 16'd512, 16'd513, 16'd514, 16'd517,
    16'd520, 16'd550, 16'd560, 16'd561, 16'd521, 16'd1080};

  localparam logic [15:0] TCP_PORTS [TCP_N] = '{
    16'd1, 16'd7, 16'd9, 16'd11, 16'd13, 16'd15, 16'd19, 16'd20, 16'd21, 16'd23,
    16'd25, 16'd37, 16'd39, 16'd42, 16'd43, 16'd53, 16'd67, 16'd68, 16'd69, 16'd70,
    16'd77, 16'd79, 16'd80, 16'd87, 16'd95, 16'd101, 16'd102, 16'd103, 16'd104,
    16'd105, 16'd109, 16'd113, 16'd117, 16'd119, 16'd123, 16'd139, 16'd143, 16'd144,
    16'd427, 16'd443, 16'd512, 16'd513, 16'd514, 16'd515, 16'd530, 16'd540, 16'd600,
    16'd1524, 16'd1080, 16'd6000, 16'd8080};

  typedef struct packed {
    logic       hit;
    logic [5:0] row;
  } known_t;

  // First matching row of the protocol's table.
  function automatic known_t known_lookup(input logic [7:0] proto,
                                          input logic [15:0] port);
    known_t r;
    r = '0;
    if (proto == PROTO_TCP) begin
      for (int i = TCP_N - 1; i >= 0; i--)
        if (TCP_PORTS[i] == port) begin
          r.hit = 1'b1;
          r.row = 6'(i);
        end
    end else if (proto == PROTO_UDP) begin
      for (int i = UDP_N - 1; i >= 0; i--)
        if (UDP_PORTS[i] == port) begin
          r.hit = 1'b1;
          r.row = 6'(i);
        end
    end
    return r;
  endfunction

  function automatic logic [3:0] service_dissector(input logic [15:0] svc,
                                                   input logic call);
    logic [3:0] d;
    case (svc)
      16'd67, 16'd68:   d = 4'd3;
      16'd69:           d = 4'd4;
      16'd80, 16'd8080: d = 4'd5;
      16'd123:          d = 4'd6;
      16'd137:          d = 4'd7;
      16'd138:          d = 4'd8;
      16'd139:          d = 4'd9;
      16'd427:          d = 4'd10;
      16'd520:          d = 4'd11;
      16'd521:          d = 4'd12;
      16'd1080:         d = call ? 4'd13 : 4'd14;
      default:          d = DIS_GENERIC;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic        start;
    logic        del;
    logic [15:0] src;
    logic [15:0] dst;
  } scan_req_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [3:0] handler;
  } scan_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/utpc_scan.sv =====
// Transient port table with its sequential scan engine: one entry per cycle,
// one shared compare. Depends on utpc_pkg.
`default_nettype none
module utpc_scan
  import utpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_req_t         req,
  input  wire logic              add,
  input  wire logic [15:0]       add_port,
  input  wire logic [3:0]        add_handler,
  output scan_rsp_t              rsp
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [16:0] ports [TRANSIENT_DEPTH];
  logic [3:0]  handlers [TRANSIENT_DEPTH];
  logic [TRANSIENT_DEPTH-1:0] valid;
  logic [TIDX_W-1:0] wp;

  logic [1:0]        state;
  logic              del;
  logic              pass2;
  logic [15:0]       src, dst;
  logic [TCNT_W-1:0] idx;
  logic [16:0]       rd_port;
  logic [3:0]        rd_handler;
  logic              rd_valid;
  logic [TIDX_W-1:0] rd_idx;
  logic [15:0]       key;
  logic              stop, match, last;

  assign key   = pass2 ? dst : src;
  assign stop  = !rd_valid || (rd_port == 17'd0);
  assign match = (rd_port == {1'b0, key});
  assign last  = (idx == TCNT_W'(TRANSIENT_DEPTH));

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (add) begin
      ports[wp]    <= {1'b0, add_port};
      handlers[wp] <= add_handler;
    end else if (state == S_CMP && del && !stop && match) begin
      ports[rd_idx] <= 17'h10000;
    end
    rd_port    <= ports[idx[TIDX_W-1:0]];
    rd_handler <= handlers[idx[TIDX_W-1:0]];
    rd_valid   <= valid[idx[TIDX_W-1:0]] && !last;
    rd_idx     <= idx[TIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      wp    <= '0;
    end else if (add) begin
      valid[wp] <= 1'b1;
      wp <= (wp == TIDX_W'(TRANSIENT_DEPTH - 1)) ? '0 : wp + 1'b1;
    end
  end

  // Done pulses for the one idle cycle after a scan; hit and handler hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp   <= '0;
      idx   <= '0;
      pass2 <= 1'b0;
      del   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rsp.done <= 1'b0;
          if (req.start) begin
            del   <= req.del;
            src   <= req.src;
            dst   <= req.dst;
            pass2 <= 1'b0;
            idx   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          idx   <= idx + 1'b1;
          state <= S_CMP;
        end
        S_CMP: begin
          if (stop) begin
            if (!del && !pass2) begin
              pass2 <= 1'b1;
              idx   <= '0;
              state <= S_READ;
            end else begin
              rsp   <= '{done: 1'b1, hit: 1'b0, handler: 4'd0};
              state <= S_IDLE;
            end
          end else if (!del && match) begin
            rsp   <= '{done: 1'b1, hit: 1'b1, handler: rd_handler};
            state <= S_IDLE;
          end else begin
            if (!last) idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/udp_tcp_port_classifier_core.sv =====
// Top level of the UDP/TCP port classifier: stream handshakes, fixed-table
// decode and control of the transient scan engine. Depends on utpc_pkg, utpc_scan.
//
// Usage: one input word per item on s_axis (kind, protocol, ports, payload
// flag, handler). Classify words give one result word on m_axis; add and
// delete words (and kind 3) give none.
// An add is registered (add_q) and written into the table in the cycle after
// acceptance, and the next word is taken the very next cycle. A classify
// that hits the well-known tables is looked up on the registered item and
// its result word is loaded into the output register once that is free.
// Otherwise the transient table is scanned one entry per cycle, source pass
// then destination pass, each pass ending at the first never-written entry
// (or one holding port 0) or at the end of the table; a classify ends at its
// first match. Delete sweeps the live part once. The scan rate is set by the
// single table read port feeding one port comparator.
// s_axis_tready is high whenever the control is idle. A result waits in the
// output register as long as m_axis_tready is low; add and delete words still
// go through, and the next classify holds its result until the register frees.
// Reset empties the transient table (valid bits) and the write pointer and
// drops any pending result.
`default_nettype none
module udp_tcp_port_classifier_core
  import utpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] kind, [9:2] protocol, [25:10] sport, [41:26] dport,
  // [42] payload_present, [46:43] handler_id, [47] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] handled, [4:1] dissector, [5] direction, [11:6] service_index,
  // [27:12] other_port, [31:28] transient_handler
  output logic [31:0]      m_axis_tdata
);
  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_KNOWN = 2'd1;
  localparam logic [1:0] T_SCAN = 2'd2;
  localparam logic [1:0] T_EMIT = 2'd3;

  logic [1:0]  state;
  logic [1:0]  kind;
  logic [7:0]  proto;
  logic [15:0] src, dst;
  logic        payload;
  logic [3:0]  hid;
  logic        accept;
  scan_req_t   req;
  scan_rsp_t   rsp;
  known_t      ks, kd;
  logic        call;
  logic [15:0] svc, other;
  logic [3:0]  dis;
  logic        out_free, emit;
  logic [31:0] known_word, scan_word;

  assign kind    = s_axis_tdata[1:0];
  assign s_axis_tready = (state == T_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;

  // Fixed-table lookups on the registered item.
  assign ks    = known_lookup(proto, src);
  assign kd    = known_lookup(proto, dst);
  assign call  = !ks.hit;
  assign svc   = call ? dst : src;
  assign other = call ? src : dst;
  always_comb begin
    if ((dst == 16'd53 || src == 16'd53) && proto != PROTO_TCP) dis = DIS_DNS;
    else if (payload) dis = service_dissector(svc, call);
    else dis = DIS_GENERIC;
  end

  // Load the output register only when it is empty or being drained.
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign known_word = {4'd0, other, (call ? kd.row : ks.row), !call, dis, 1'b1};
  assign scan_word  = rsp.hit ? {rsp.handler, 23'd0, DIS_TRANSIENT, 1'b1}
                              : {27'd0, DIS_NONE, 1'b0};
  assign emit = out_free &&
                (((state == T_KNOWN) && (ks.hit || kd.hit)) || (state == T_EMIT));

  always_ff @(posedge clk) begin
    if (accept) begin
      proto   <= s_axis_tdata[9:2];
      src     <= s_axis_tdata[25:10];
      dst     <= s_axis_tdata[41:26];
      payload <= s_axis_tdata[42];
      hid     <= s_axis_tdata[46:43];
    end
    if (rst) begin
      req.start <= 1'b0;
    end else if (accept && kind == KIND_DELETE) begin
      req <= '{start: 1'b1, del: 1'b1, src: s_axis_tdata[25:10], dst: 16'd0};
    end else if (state == T_KNOWN && !(ks.hit || kd.hit)) begin
      req <= '{start: 1'b1, del: 1'b0, src: src, dst: dst};
    end else begin
      req.start <= 1'b0;
    end
  end

  logic add_q;
  always_ff @(posedge clk) begin
    if (rst) add_q <= 1'b0;
    else add_q <= accept && kind == KIND_ADD;
  end

  utpc_scan u_scan (
    .clk, .rst, .req, .add(add_q), .add_port(src), .add_handler(hid), .rsp
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (emit) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) m_axis_tdata <= (state == T_EMIT) ? scan_word : known_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_CLASSIFY: state <= T_KNOWN;
              KIND_DELETE:   state <= T_SCAN;
              default:       state <= T_IDLE;
            endcase
          end
        end
        T_KNOWN: begin
          if (!(ks.hit || kd.hit)) state <= T_SCAN;
          else if (out_free) state <= T_IDLE;
        end
        T_SCAN: begin
          // Drop delete completions; hold classify results for the output.
          if (rsp.done) state <= req.del ? T_IDLE : T_EMIT;
        end
        T_EMIT: begin
          if (out_free) state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != T_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == T_SCAN) else $error("stray scan done");
`endif
endmodule
`default_nettype wire
